@@ rtl/tsrp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrp_pkg
// Shared types and constants of the TCP segment receive parser.
// ----------------------------------------------------------------------------
package tsrp_pkg;

  // Frame byte positions, counted from the Ethernet destination address
  localparam int ETH_TYPE_HI_POS = 12;
  localparam int ETH_TYPE_LO_POS = 13;
  localparam int IP_VER_IHL_POS  = 14;
  localparam int IP_LEN_HI_POS   = 16;
  localparam int IP_LEN_LO_POS   = 17;
  localparam int IP_PROTO_POS    = 23;
  localparam int ETH_HDR_BYTES   = 14;
  localparam int MIN_FRAME_BYTES = 54;

  // Offsets inside the TCP header
  localparam int TCP_SRC_END    = 2;
  localparam int TCP_DST_END    = 4;
  localparam int TCP_SEQ_END    = 8;
  localparam int TCP_ACK_END    = 12;
  localparam int TCP_OFF_POS    = 12;
  localparam int TCP_FLAGS_POS  = 13;
  localparam int TCP_THRU_FLAGS = 14;

  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

  localparam logic [7:0] ETHTYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETHTYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_TCP    = 8'd6;

  localparam logic [10:0] PAYLOAD_LIMIT_RESET = 11'd1600;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    CFG_LOCAL_PORT    = 2'd0,
    CFG_REMOTE_PORT   = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [10:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        accepted;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flag_bits;
    logic [10:0] payload_count;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ rtl/tsrp_parser.sv @@
// ----------------------------------------------------------------------------
// tsrp_parser
// Input register, header state and per-byte parse; emits up to two results.
// ----------------------------------------------------------------------------
module tsrp_parser
  import tsrp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  cfg_t       cfg,
  input  logic       space_ok,
  output push_t      push
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);

  logic          v_r;
  logic [7:0]    b_r;
  logic          end_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          eth_ok_r, eth_ok_nxt;
  logic          proto_ok_r, proto_ok_nxt;
  logic [5:0]    ihl_r, ihl_nxt;
  logic [15:0]   iptl_r, iptl_nxt;
  logic [5:0]    thb_r, thb_nxt;
  logic [15:0]   src_r, src_nxt;
  logic [15:0]   dst_r, dst_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [31:0]   ack_r, ack_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [10:0]   sent_r, sent_nxt;

  logic          fire;
  logic          keep;
  logic [PW-1:0] tcp_base;
  logic          in_tcp;
  logic [PW-1:0] off;
  logic [6:0]    hdr_sum;
  logic [15:0]   room_full;
  logic [10:0]   room;
  logic          hg_cur;
  logic          hg_nxt;
  logic          len_ok;
  logic          pay;
  res_t          e_pay;
  res_t          e_sum;

  assign fire     = v_r && space_ok;
  assign in_ready = !v_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (fire) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_r   <= in_byte;
      end_r <= in_end;
    end
  end

  always_comb begin
    keep         = pos_r != POS_MAX;
    eth_ok_nxt   = eth_ok_r;
    proto_ok_nxt = proto_ok_r;
    ihl_nxt      = ihl_r;
    iptl_nxt     = iptl_r;
    thb_nxt      = thb_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    seq_nxt      = seq_r;
    ack_nxt      = ack_r;
    flags_nxt    = flags_r;

    // ihl_r is still zero at the IHL byte itself, so in_tcp is false there
    tcp_base = PW'(ETH_HDR_BYTES) + PW'(ihl_r);
    in_tcp   = (ihl_r >= MIN_HDR_BYTES) && (pos_r >= tcp_base);
    off      = pos_r - tcp_base;

    if (keep) begin
      if (pos_r == PW'(ETH_TYPE_HI_POS)) begin
        eth_ok_nxt = b_r == ETHTYPE_IPV4_HI;
      end else if (pos_r == PW'(ETH_TYPE_LO_POS)) begin
        eth_ok_nxt = eth_ok_r && (b_r == ETHTYPE_IPV4_LO);
      end else if (pos_r == PW'(IP_VER_IHL_POS)) begin
        ihl_nxt = {b_r[3:0], 2'b00};
      end else if (pos_r == PW'(IP_LEN_HI_POS)) begin
        iptl_nxt = {b_r, 8'h00};
      end else if (pos_r == PW'(IP_LEN_LO_POS)) begin
        iptl_nxt = {iptl_r[15:8], b_r};
      end else if (pos_r == PW'(IP_PROTO_POS)) begin
        proto_ok_nxt = b_r == IP_PROTO_TCP;
      end

      if (in_tcp) begin
        if (off < PW'(TCP_SRC_END)) begin
          src_nxt = {src_r[7:0], b_r};
        end else if (off < PW'(TCP_DST_END)) begin
          dst_nxt = {dst_r[7:0], b_r};
        end else if (off < PW'(TCP_SEQ_END)) begin
          seq_nxt = {seq_r[23:0], b_r};
        end else if (off < PW'(TCP_ACK_END)) begin
          ack_nxt = {ack_r[23:0], b_r};
        end else if (off == PW'(TCP_OFF_POS)) begin
          thb_nxt = {b_r[7:4], 2'b00};
        end else if (off == PW'(TCP_FLAGS_POS)) begin
          flags_nxt = b_r;
        end
      end
    end

    // Payload starts at offset >= 20, where all header fields are settled
    hdr_sum   = {1'b0, ihl_r} + {1'b0, thb_r};
    room_full = (iptl_r > 16'(hdr_sum)) ? (iptl_r - 16'(hdr_sum)) : 16'd0;
    room      = (room_full > 16'(cfg.payload_limit)) ? cfg.payload_limit : room_full[10:0];
    hg_cur    = eth_ok_r && proto_ok_r && (ihl_r >= MIN_HDR_BYTES) &&
                (thb_r >= MIN_HDR_BYTES) && (src_r == cfg.remote_port) &&
                (dst_r == cfg.local_port);
    pay       = keep && in_tcp && (thb_r >= MIN_HDR_BYTES) && (off >= PW'(thb_r)) &&
                hg_cur && (sent_r < room);

    sent_nxt = sent_r + 11'(pay);
    pos_nxt  = keep ? (pos_r + PW'(1)) : pos_r;

    hg_nxt = eth_ok_nxt && proto_ok_nxt && (ihl_nxt >= MIN_HDR_BYTES) &&
             (thb_nxt >= MIN_HDR_BYTES) && (src_nxt == cfg.remote_port) &&
             (dst_nxt == cfg.local_port);
    len_ok = (pos_nxt >= PW'(MIN_FRAME_BYTES)) &&
             (pos_nxt >= PW'(ETH_HDR_BYTES + TCP_THRU_FLAGS) + PW'(ihl_nxt));

    e_pay               = '0;
    e_pay.kind          = KIND_PAYLOAD;
    e_pay.payload_byte  = b_r;

    e_sum               = '0;
    e_sum.kind          = KIND_SUMMARY;
    e_sum.accepted      = hg_nxt && len_ok;
    e_sum.seq_number    = seq_nxt;
    e_sum.ack_number    = ack_nxt;
    e_sum.tcp_flag_bits = flags_nxt;
    e_sum.payload_count = sent_nxt;
    e_sum.run_last      = 1'b1;

    push.cnt    = fire ? (2'(pay) + 2'(end_r)) : 2'd0;
    push.first  = pay ? e_pay : e_sum;
    push.second = e_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && end_r)) begin
      pos_r      <= '0;
      eth_ok_r   <= 1'b0;
      proto_ok_r <= 1'b0;
      ihl_r      <= '0;
      iptl_r     <= '0;
      thb_r      <= '0;
      src_r      <= '0;
      dst_r      <= '0;
      seq_r      <= '0;
      ack_r      <= '0;
      flags_r    <= '0;
      sent_r     <= '0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      eth_ok_r   <= eth_ok_nxt;
      proto_ok_r <= proto_ok_nxt;
      ihl_r      <= ihl_nxt;
      iptl_r     <= iptl_nxt;
      thb_r      <= thb_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      seq_r      <= seq_nxt;
      ack_r      <= ack_nxt;
      flags_r    <= flags_nxt;
      sent_r     <= sent_nxt;
    end
  end

endmodule

@@ rtl/tsrp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tsrp_out_fifo
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module tsrp_out_fifo
  import tsrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rp_r];
  assign space_ok  = cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(push.cnt);
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + FIFO_AW'(1)] <= push.second;
    end
  end

endmodule

@@ rtl/tcp_segment_receive_parser_core.sv @@
// ----------------------------------------------------------------------------
// tcp_segment_receive_parser_core
// Ethernet/IPv4/TCP receive parser: payload bytes out, summary per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle (in_tlast on the last byte). Each accepted
// byte passes an input register and the combinational parse logic, then
// enters a four-entry result queue, from which its first result is presented
// on the output. Payload bytes go out as kind 0 results; the end byte gives a
// kind 1 summary with out_tlast set. An end byte that is also a payload byte
// gives two results, so input stalls only when the queue lacks room for two
// results. Drop the payload of a summary whose accepted bit is 0.
// Configuration is written through cfg_* (always ready) and must only change
// while the block is idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module tcp_segment_receive_parser_core
  import tsrp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // frame_end

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [8] accepted, [40:9] seq_number, [72:41] ack_number,
  // [80:73] tcp_flag_bits, [91:81] payload_count, [95:92] zero
  output logic [95:0] out_tdata,
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,  // run_last

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  push_t push;
  logic  space_ok;
  res_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_port    <= '0;
      cfg_r.remote_port   <= '0;
      cfg_r.payload_limit <= PAYLOAD_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_PORT:    cfg_r.local_port    <= cfg_data;
        CFG_REMOTE_PORT:   cfg_r.remote_port   <= cfg_data;
        CFG_PAYLOAD_LIMIT: cfg_r.payload_limit <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  tsrp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .cfg     (cfg_r),
    .space_ok(space_ok),
    .push    (push)
  );

  tsrp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {4'b0000, out_res.payload_count, out_res.tcp_flag_bits,
                      out_res.ack_number, out_res.seq_number, out_res.accepted,
                      out_res.payload_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.run_last;

endmodule

@@ tb/sv/tb_tcp_segment_receive_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_segment_receive_parser_core
// Self-checking bench for the Ethernet/IPv4/TCP receive parser.
// ----------------------------------------------------------------------------
// Frames are built byte by byte and pushed through the input stream. A
// byte-level predictor tracks header capture, connection match and payload
// clamping, and queues the payload items and the end-of-frame summary that
// each accepted byte should produce. Every output item is compared field by
// field against the oldest queued one. Directed frames cover header errors,
// length clamps, register extremes and an oversize frame; random frames
// follow under three backpressure mixes.
// ----------------------------------------------------------------------------
module tb_tcp_segment_receive_parser_core;
  import tsrp_pkg::*;

  localparam int MAX_FRAME = 2048;

  localparam int POS_TYPE_HI = 12;
  localparam int POS_TYPE_LO = 13;
  localparam int POS_VER_IHL = 14;
  localparam int POS_LEN_HI  = 16;
  localparam int POS_LEN_LO  = 17;
  localparam int POS_PROTO   = 23;
  localparam int ETH_BYTES   = 14;
  localparam int MIN_HDR     = 20;
  localparam int MIN_FRAME   = 54;
  localparam int OFF_SRC_END = 2;
  localparam int OFF_DST_END = 4;
  localparam int OFF_SEQ_END = 8;
  localparam int OFF_ACK_END = 12;
  localparam int OFF_DOFF    = 12;
  localparam int OFF_FLAGS   = 13;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [10:0] LIMIT_RESET    = 11'd1600;

  typedef struct {
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [15:0] tot_len;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] seq;
    logic [31:0] ack;
    int          pay_len;
    int          pad_len;
    int          cut_len;
  } seg_spec_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_LOCAL_PORT;
  logic [15:0] cfg_data = 16'h0000;

  int in_idle_pct;
  int out_idle_pct;
  int bytes_accepted;
  int mismatches;

  // predictor state
  logic [15:0] reg_local;
  logic [15:0] reg_remote;
  logic [10:0] reg_limit;
  int          at_pos;
  bit          ipv4_ok;
  bit          tcp_ok;
  int          ip_hlen;
  int          ip_len_field;
  int          tcp_hlen;
  logic [15:0] sport_cap;
  logic [15:0] dport_cap;
  logic [31:0] seq_cap;
  logic [31:0] ack_cap;
  logic [7:0]  flags_cap;
  int          delivered;

  res_t expected_results[$];

  tcp_segment_receive_parser_core #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame();
    at_pos       = 0;
    ipv4_ok      = 1'b0;
    tcp_ok       = 1'b0;
    ip_hlen      = 0;
    ip_len_field = 0;
    tcp_hlen     = 0;
    sport_cap    = '0;
    dport_cap    = '0;
    seq_cap      = '0;
    ack_cap      = '0;
    flags_cap    = '0;
    delivered    = 0;
  endfunction

  function automatic bit connection_ok();
    return ipv4_ok && tcp_ok && ip_hlen >= MIN_HDR && tcp_hlen >= MIN_HDR &&
           sport_cap == reg_remote && dport_cap == reg_local;
  endfunction

  task automatic predict_parse(input logic [7:0] b, input logic last);
    res_t r;
    int   off;
    int   room;
    bit   fwd;
    fwd = 1'b0;
    if (at_pos < MAX_FRAME) begin
      case (at_pos)
        POS_TYPE_HI: ipv4_ok = (b == ETHERTYPE_IPV4[15:8]);
        POS_TYPE_LO: ipv4_ok = ipv4_ok && (b == ETHERTYPE_IPV4[7:0]);
        POS_VER_IHL: ip_hlen = b[3:0] * 4;
        POS_LEN_HI:  ip_len_field = {b, 8'h00};
        POS_LEN_LO:  ip_len_field = ip_len_field | b;
        POS_PROTO:   tcp_ok = (b == PROTO_TCP);
        default: ;
      endcase
      if (ip_hlen >= MIN_HDR && at_pos >= ETH_BYTES + ip_hlen) begin
        off = at_pos - ETH_BYTES - ip_hlen;
        if (off < OFF_SRC_END) sport_cap = {sport_cap[7:0], b};
        else if (off < OFF_DST_END) dport_cap = {dport_cap[7:0], b};
        else if (off < OFF_SEQ_END) seq_cap = {seq_cap[23:0], b};
        else if (off < OFF_ACK_END) ack_cap = {ack_cap[23:0], b};
        else if (off == OFF_DOFF) tcp_hlen = b[7:4] * 4;
        else if (off == OFF_FLAGS) flags_cap = b;
        if (tcp_hlen >= MIN_HDR && off >= tcp_hlen && connection_ok()) begin
          room = ip_len_field - ip_hlen - tcp_hlen;
          if (room < 0) room = 0;
          if (room > reg_limit) room = reg_limit;
          if (delivered < room) begin
            delivered++;
            fwd = 1'b1;
          end
        end
      end
      at_pos++;
    end
    if (fwd) begin
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      expected_results.push_back(r);
    end
    if (last) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.accepted = connection_ok() && at_pos >= MIN_FRAME &&
                   at_pos >= ETH_BYTES + ip_hlen + OFF_FLAGS + 1;
      r.seq_number = seq_cap;
      r.ack_number = ack_cap;
      r.tcp_flag_bits = flags_cap;
      r.payload_count = delivered[10:0];
      r.run_last = 1'b1;
      expected_results.push_back(r);
      clear_frame();
    end
  endtask

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("item with none expected", out_tdata[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("kind", 32'(out_tuser), 32'(want.kind));
        if (out_tdata[7:0] !== want.payload_byte)
          report_mismatch("payload_byte", 32'(out_tdata[7:0]), 32'(want.payload_byte));
        if (out_tdata[8] !== want.accepted)
          report_mismatch("accepted", 32'(out_tdata[8]), 32'(want.accepted));
        if (out_tdata[40:9] !== want.seq_number)
          report_mismatch("seq_number", out_tdata[40:9], want.seq_number);
        if (out_tdata[72:41] !== want.ack_number)
          report_mismatch("ack_number", out_tdata[72:41], want.ack_number);
        if (out_tdata[80:73] !== want.tcp_flag_bits)
          report_mismatch("tcp_flag_bits", 32'(out_tdata[80:73]),
                          32'(want.tcp_flag_bits));
        if (out_tdata[91:81] !== want.payload_count)
          report_mismatch("payload_count", 32'(out_tdata[91:81]),
                          32'(want.payload_count));
        if (out_tlast !== want.run_last)
          report_mismatch("run_last", 32'(out_tlast), 32'(want.run_last));
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_accepted++;
    predict_parse(b, last);
  endtask

  // sender holds off until every queued item has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOCAL_PORT:    reg_local = val;
      CFG_REMOTE_PORT:   reg_remote = val;
      CFG_PAYLOAD_LIMIT: reg_limit = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic seg_spec_t good_spec(input int pay);
    seg_spec_t s;
    s.eth_type = ETHERTYPE_IPV4;
    s.ihl      = 4'd5;
    s.doff     = 4'd5;
    s.proto    = PROTO_TCP;
    s.flags    = rand_byte();
    s.src      = reg_remote;
    s.dst      = reg_local;
    s.seq      = $urandom;
    s.ack      = $urandom;
    s.pay_len  = pay;
    s.pad_len  = 0;
    s.cut_len  = 0;
    s.tot_len  = 16'(2 * MIN_HDR + pay);
    return s;
  endfunction

  task automatic send_segment(input seg_spec_t s);
    logic [7:0] fr[$];
    int         ip_bytes;
    int         tcp_bytes;
    int         n;
    ip_bytes  = (s.ihl < 5) ? MIN_HDR : s.ihl * 4;
    tcp_bytes = (s.doff < 5) ? MIN_HDR : s.doff * 4;
    repeat (12) fr.push_back(rand_byte());
    fr.push_back(s.eth_type[15:8]);
    fr.push_back(s.eth_type[7:0]);
    for (int i = 0; i < ip_bytes; i++) begin
      case (i)
        0:       fr.push_back({4'h4, s.ihl});
        2:       fr.push_back(s.tot_len[15:8]);
        3:       fr.push_back(s.tot_len[7:0]);
        9:       fr.push_back(s.proto);
        default: fr.push_back(rand_byte());
      endcase
    end
    for (int i = 0; i < tcp_bytes; i++) begin
      case (i)
        0:          fr.push_back(s.src[15:8]);
        1:          fr.push_back(s.src[7:0]);
        2:          fr.push_back(s.dst[15:8]);
        3:          fr.push_back(s.dst[7:0]);
        4, 5, 6, 7: fr.push_back(s.seq[8 * (7 - i) +: 8]);
        8, 9, 10, 11: fr.push_back(s.ack[8 * (11 - i) +: 8]);
        OFF_DOFF:   fr.push_back({s.doff, 4'($urandom)});
        OFF_FLAGS:  fr.push_back(s.flags);
        default:    fr.push_back(rand_byte());
      endcase
    end
    repeat (s.pay_len) fr.push_back(rand_byte());
    repeat (s.pad_len) fr.push_back(rand_byte());
    if (s.cut_len > 0 && s.cut_len < fr.size()) fr = fr[0:s.cut_len - 1];
    n = fr.size();
    for (int i = 0; i < n; i++) send_byte(fr[i], i == n - 1);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_byte(), i == n - 1);
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_reset_values();
    send_segment(good_spec(5));
    send_segment(good_spec(1));
  endtask

  task automatic test_field_extremes();
    seg_spec_t s;
    settle();
    write_reg(CFG_LOCAL_PORT, 16'hFFFF);
    write_reg(CFG_REMOTE_PORT, 16'hFFFF);
    write_reg(CFG_PAYLOAD_LIMIT, 16'd2047);
    s = good_spec(8);
    s.seq = '1;
    s.ack = '0;
    s.flags = 8'hFF;
    send_segment(s);
    s = good_spec(0);
    s.seq = '0;
    s.ack = '1;
    s.flags = 8'h00;
    send_segment(s);
    settle();
    write_reg(CFG_PAYLOAD_LIMIT, 16'd0);
    send_segment(good_spec(6));
  endtask

  task automatic test_header_checks();
    seg_spec_t s;
    settle();
    write_reg(CFG_PAYLOAD_LIMIT, 16'd4);
    send_segment(good_spec(9));
    s = good_spec(3); s.eth_type = 16'h0900; send_segment(s);
    s = good_spec(3); s.eth_type = 16'h0801; send_segment(s);
    s = good_spec(3); s.proto = PROTO_UDP; send_segment(s);
    s = good_spec(3); s.ihl = 4'd4; send_segment(s);
    s = good_spec(3); s.ihl = 4'd0; send_segment(s);
    s = good_spec(3); s.ihl = 4'd15; s.tot_len = 16'd83; send_segment(s);
    s = good_spec(3); s.doff = 4'd4; send_segment(s);
    s = good_spec(2); s.doff = 4'd15; s.tot_len = 16'd82; send_segment(s);
    s = good_spec(3); s.src = reg_remote ^ 16'h0001; send_segment(s);
    s = good_spec(3); s.dst = reg_local ^ 16'h8000; send_segment(s);
  endtask

  task automatic test_length_clamps();
    seg_spec_t s;
    settle();
    write_reg(CFG_PAYLOAD_LIMIT, 16'd2047);
    s = good_spec(7); s.tot_len = 16'd30; send_segment(s);
    s = good_spec(6); s.tot_len = 16'd96; send_segment(s);
    s = good_spec(3); s.pad_len = 10; send_segment(s);
    send_segment(good_spec(0));
    s = good_spec(0); s.cut_len = MIN_FRAME - 1; send_segment(s);
    // long IP header, frame stops short of the TCP flags byte
    s = good_spec(4); s.ihl = 4'd15; s.tot_len = 16'd84; s.cut_len = 80;
    send_segment(s);
    send_noise(1);
  endtask

  task automatic test_oversize_frame();
    seg_spec_t s;
    s = good_spec(2100);
    s.tot_len = 16'hFFFF;
    send_segment(s);
  endtask

  task automatic send_random_frame();
    seg_spec_t s;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_noise($urandom_range(1, 60));
    end else begin
      s = good_spec($urandom_range(0, 24));
      if ($urandom_range(9) == 0) s.ihl = 4'($urandom_range(6, 15));
      if ($urandom_range(9) == 0) s.doff = 4'($urandom_range(6, 15));
      s.tot_len = 16'(s.ihl * 4 + s.doff * 4 + s.pay_len);
      if ($urandom_range(5) == 0) s.tot_len = 16'($urandom_range(0, 140));
      if ($urandom_range(15) == 0) s.tot_len = 16'($urandom);
      if ($urandom_range(3) == 0) s.pad_len = $urandom_range(1, 12);
      if (pick >= 80) begin
        case ($urandom_range(7))
          0: s.eth_type = 16'($urandom);
          1: s.proto = rand_byte();
          2: s.ihl = 4'($urandom_range(0, 4));
          3: s.doff = 4'($urandom_range(0, 4));
          4: s.src = 16'($urandom);
          5: s.dst = 16'($urandom);
          6: s.cut_len = $urandom_range(1, MIN_FRAME + 5);
          default: s.cut_len = $urandom_range(MIN_FRAME, MIN_FRAME + 40);
        endcase
      end
      send_segment(s);
    end
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct,
                                     input logic [10:0] max_pay);
    int goal;
    settle();
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    write_reg(CFG_LOCAL_PORT, 16'($urandom));
    write_reg(CFG_REMOTE_PORT, 16'($urandom));
    write_reg(CFG_PAYLOAD_LIMIT, 16'($urandom_range(0, max_pay)));
    goal = bytes_accepted + 450;
    while (bytes_accepted < goal) begin
      if ($urandom_range(9) == 0) settle();
      send_random_frame();
    end
  endtask

  initial begin
    in_idle_pct    = 34;
    out_idle_pct   = 88;
    bytes_accepted = 0;
    mismatches     = 0;
    reg_local      = '0;
    reg_remote     = '0;
    reg_limit      = LIMIT_RESET;
    clear_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_header_checks();
    test_length_clamps();
    test_oversize_frame();
    test_random_traffic(34, 88, 11'd30);
    test_random_traffic(88, 34, 11'd2047);
    test_random_traffic(0, 0, 11'd20);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
